// ===== rtl/mtg_pkg.sv =====
// Shared types, constants and the tempering function of the MT19937 generator.
package mtg_pkg;

  localparam int STATE_WORDS   = 624;
  localparam int MIDDLE_OFFSET = 397;
  localparam int IDX_W         = 10;
  localparam int WORD_W        = 32;

  localparam logic [IDX_W-1:0] LAST_IDX     = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] REGEN_IDX    = IDX_W'(STATE_WORDS);
  localparam logic [IDX_W-1:0] UNSEEDED_IDX = IDX_W'(STATE_WORDS + 1);

  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908b0df;
  localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h80000000;
  localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fffffff;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;
  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd69069;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;

  typedef enum logic {
    CMD_DRAW = 1'b0,
    CMD_SEED = 1'b1
  } cmd_t;

  typedef struct packed {
    logic              valid;
    cmd_t              cmd;
    logic [WORD_W-1:0] seed;
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_PRIME,
    ST_TW_READ,
    ST_TW_CALC,
    ST_DRAW_READ,
    ST_DRAW_OUT
  } eng_state_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] y;
    y = x;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== rtl/mtg_front.sv =====
// Two-entry command queue that accepts and holds incoming items.
module mtg_front
  import mtg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              cmd,
  input  logic [WORD_W-1:0] seed_value,
  output op_t               head,
  input  logic              head_pop
);

  cmd_t              cmd_q  [2];
  logic [WORD_W-1:0] seed_q [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = head_pop && (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (!do_push && do_pop) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      cmd_q[wr_ptr]  <= cmd_t'(cmd);
      seed_q[wr_ptr] <= seed_value;
    end
  end

  always_comb begin
    head.valid = (count != 2'd0);
    head.cmd   = cmd_q[rd_ptr];
    head.seed  = seed_q[rd_ptr];
  end

endmodule

// ===== rtl/mtg_engine.sv =====
// Word store, seeding, twist regeneration, tempering and the result register.
module mtg_engine
  import mtg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  op_t               head,
  output logic              head_pop,
  output logic              empty,
  input  logic              pop,
  output logic [WORD_W-1:0] random_word
);

  logic [WORD_W-1:0] mem [STATE_WORDS];
  logic [WORD_W-1:0] rdata_a;
  logic [WORD_W-1:0] rdata_b;

  eng_state_t        state;
  eng_state_t        state_next;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  cnt;
  logic [WORD_W-1:0] v;
  logic [WORD_W-1:0] cur;
  logic              out_valid;
  logic [WORD_W-1:0] out_word;

  logic              mem_we;
  logic [WORD_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  addr_a;
  logic [IDX_W-1:0]  addr_b;
  logic [IDX_W-1:0]  nxt_idx;
  logic [IDX_W-1:0]  far_sum;
  logic [IDX_W-1:0]  far_idx;
  logic [WORD_W-1:0] y;
  logic [WORD_W-1:0] twisted;
  logic              out_free;
  logic              cnt_last;

  assign cnt_last = (cnt == LAST_IDX);
  assign out_free = !out_valid || pop;
  assign nxt_idx  = cnt_last ? '0 : cnt + IDX_W'(1);
  assign far_sum  = cnt + IDX_W'(MIDDLE_OFFSET);
  assign far_idx  = (far_sum >= REGEN_IDX) ? far_sum - REGEN_IDX : far_sum;
  assign y        = (cur & HIGH_BIT) | (rdata_a & LOW_BITS);
  assign twisted  = rdata_b ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt] <= mem_wdata;
    end
    rdata_a <= mem[addr_a];
    rdata_b <= mem[addr_b];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (head.valid) begin
          if (head.cmd == CMD_SEED || idx == UNSEEDED_IDX) begin
            state_next = ST_SEED;
          end else if (idx == REGEN_IDX) begin
            state_next = ST_PRIME;
          end else begin
            state_next = ST_DRAW_READ;
          end
        end
      end
      ST_SEED: begin
        if (cnt_last) begin
          state_next = (head.cmd == CMD_SEED) ? ST_IDLE : ST_PRIME;
        end
      end
      ST_PRIME:     state_next = ST_TW_READ;
      ST_TW_READ:   state_next = ST_TW_CALC;
      ST_TW_CALC:   state_next = cnt_last ? ST_DRAW_READ : ST_TW_READ;
      ST_DRAW_READ: state_next = ST_DRAW_OUT;
      ST_DRAW_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = v;
    addr_a    = (idx < REGEN_IDX) ? idx : '0;
    addr_b    = '0;
    head_pop  = 1'b0;
    case (state)
      ST_SEED: begin
        mem_we   = 1'b1;
        head_pop = cnt_last && (head.cmd == CMD_SEED);
      end
      ST_PRIME: begin
        addr_a = '0;
      end
      ST_TW_READ: begin
        addr_a = nxt_idx;
        addr_b = far_idx;
      end
      ST_TW_CALC: begin
        mem_we    = 1'b1;
        mem_wdata = twisted;
      end
      ST_DRAW_OUT: begin
        head_pop = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= UNSEEDED_IDX;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DRAW_OUT && out_free) begin
        out_valid <= 1'b1;
        idx       <= idx + IDX_W'(1);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          cnt <= '0;
        end
        ST_SEED: begin
          if (cnt_last) begin
            idx <= REGEN_IDX;
          end else begin
            cnt <= cnt + IDX_W'(1);
          end
        end
        ST_PRIME: begin
          cnt <= '0;
        end
        ST_TW_CALC: begin
          if (cnt_last) begin
            idx <= '0;
          end else begin
            cnt <= cnt + IDX_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        v <= (head.cmd == CMD_SEED) ? head.seed : DEFAULT_SEED;
      end
      ST_SEED: begin
        v <= WORD_W'(v * SEED_MULT);
      end
      ST_TW_READ: begin
        if (cnt == '0) begin
          cur <= rdata_a;
        end
      end
      ST_TW_CALC: begin
        cur <= rdata_a;
      end
      ST_DRAW_OUT: begin
        if (out_free) begin
          out_word <= temper(rdata_a);
        end
      end
      default: begin
      end
    endcase
  end

  assign empty       = !out_valid;
  assign random_word = out_word;

endmodule

// ===== rtl/mersenne_twister_generator_core.sv =====
// Top level of the MT19937 pseudorandom word generator.
//
// Items enter through a queue-like port: an item is taken when push is high
// and full is low. A draw item (cmd low) yields one tempered 32-bit word; a
// reseed item (cmd high) fills the 624-word store from seed_value and yields
// nothing. Results leave through a queue-like port: random_word is valid while
// empty is low and is taken when pop is high.
// A draw passes from the head of the internal command queue through the idle,
// read and output states to the result register; the output state waits while
// the result register is full. Every 624th draw, and the first draw after a
// reseed, first regenerates the store, reading and then rewriting each word
// through the single write port. A reseed walks the store one word per cycle
// once decoded. The first draw with no reseed seeds with 4357, then regenerates.
// Reset empties both queues and marks the generator unseeded; the store itself
// is not cleared. A two-entry command queue keeps taking items while a result
// waits; when pop stays low the engine holds its next result until the result
// register frees up, and full rises once the command queue fills.
module mersenne_twister_generator_core
  import mtg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              cmd,
  input  logic [WORD_W-1:0] seed_value,
  output logic              empty,
  input  logic              pop,
  output logic [WORD_W-1:0] random_word
);

  op_t  head;
  logic head_pop;

  mtg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd        (cmd),
    .seed_value (seed_value),
    .head       (head),
    .head_pop   (head_pop)
  );

  mtg_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_pop    (head_pop),
    .empty       (empty),
    .pop         (pop),
    .random_word (random_word)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("Queues not empty after reset.");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (rst)
    head_pop |-> head.valid)
    else $error("Engine retired an item with no item queued.");

  a_head_holds: assert property (@(posedge clk) disable iff (rst)
    head.valid && !head_pop |=> head.valid && $stable(head.seed) && $stable(head.cmd))
    else $error("Queued item changed before the engine retired it.");

endmodule

// ===== sim/tb_mersenne_twister_generator_core.sv =====
// Testbench for the MT19937 generator core, checked against a predictor of its own.
`timescale 1ns / 100ps

module tb_mersenne_twister_generator_core;
  import mtg_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 2000;
  localparam int MAX_PRINTED    = 40;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  logic              cmd = CMD_DRAW;
  logic [WORD_W-1:0] seed_value = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [WORD_W-1:0] random_word;

  bit   [WORD_W-1:0] mt_store [STATE_WORDS];
  int unsigned       mt_pos = STATE_WORDS + 1;
  bit   [WORD_W-1:0] pending_words [$];

  int mismatches    = 0;
  int send_idle_pct = 24;
  int pop_idle_pct  = 24;
  int stall_cycles  = 0;

  mersenne_twister_generator_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd        (cmd),
    .seed_value (seed_value),
    .empty      (empty),
    .pop        (pop),
    .random_word(random_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void mt_seed(bit [WORD_W-1:0] s);
    bit [WORD_W-1:0] v;
    v = s;
    for (int i = 0; i < STATE_WORDS; i++) begin
      mt_store[i] = v;
      v = v * SEED_MULT;
    end
    mt_pos = STATE_WORDS;
  endfunction

  function automatic void mt_twist();
    bit [WORD_W-1:0] y;
    bit [WORD_W-1:0] w;
    for (int k = 0; k < STATE_WORDS; k++) begin
      y = (mt_store[k] & HIGH_BIT) | (mt_store[(k + 1) % STATE_WORDS] & LOW_BITS);
      w = mt_store[(k + MIDDLE_OFFSET) % STATE_WORDS] ^ (y >> 1);
      if (y[0]) begin
        w = w ^ TWIST_MATRIX;
      end
      mt_store[k] = w;
    end
    mt_pos = 0;
  endfunction

  function automatic bit [WORD_W-1:0] next_tempered_word();
    bit [WORD_W-1:0] y;
    if (mt_pos >= STATE_WORDS) begin
      if (mt_pos == STATE_WORDS + 1) begin
        mt_seed(DEFAULT_SEED);
      end
      mt_twist();
    end
    y = mt_store[mt_pos];
    mt_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [WORD_W-1:0] pick_seed();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return HIGH_BIT;
      3: return 32'd1;
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTED) begin
      $display("%0t: mismatch: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // Leaves push high on return so that back-to-back items need no gap.
  task automatic send_item(cmd_t op, logic [WORD_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    cmd        <= op;
    seed_value <= s;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
    if (op == CMD_SEED) begin
      mt_seed(s);
    end else begin
      pending_words.push_back(next_tempered_word());
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) begin
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= pop_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %08h", random_word));
      end else begin
        if (random_word !== pending_words[0]) begin
          report_mismatch($sformatf("random_word %08h, expected %08h",
                                    random_word, pending_words[0]));
        end
        void'(pending_words.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("tb_mersenne_twister_generator_core: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // With no reseed the first draw must use the default seed.
  task automatic test_unseeded_draws();
    send_item(CMD_DRAW, '0);
    send_item(CMD_DRAW, '1);
    send_item(CMD_DRAW, $urandom());
  endtask

  task automatic test_seed_extremes();
    send_item(CMD_SEED, '0);
    send_item(CMD_DRAW, '0);
    send_item(CMD_DRAW, '1);
    send_item(CMD_SEED, '1);
    send_item(CMD_DRAW, '1);
    send_item(CMD_DRAW, '0);
    send_item(CMD_SEED, 32'd1);
    send_item(CMD_SEED, HIGH_BIT);
    send_item(CMD_DRAW, $urandom());
    send_item(CMD_SEED, 32'haaaa_aaaa);
    send_item(CMD_DRAW, 32'h5555_5555);
    send_item(CMD_SEED, 32'h5555_5555);
    send_item(CMD_DRAW, 32'haaaa_aaaa);
    send_item(CMD_SEED, DEFAULT_SEED);
    send_item(CMD_DRAW, $urandom());
  endtask

  // A long unbroken run of draws that crosses the end of the store.
  task automatic test_index_wrap(int draws);
    send_idle_pct = 0;
    pop_idle_pct  = 0;
    send_item(CMD_SEED, $urandom());
    for (int n = 0; n < draws; n++) begin
      send_item(CMD_DRAW, $urandom());
    end
    wait_drained();
    send_idle_pct = 24;
    pop_idle_pct  = 24;
  endtask

  task automatic test_random_mix(int count);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) begin
        wait_drained();
      end
      if ($urandom_range(99) < 3) begin
        send_item(CMD_SEED, pick_seed());
      end else begin
        send_item(CMD_DRAW, $urandom());
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_unseeded_draws();
    test_seed_extremes();
    wait_drained();
    test_index_wrap(700);
    test_random_mix(1030);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_words.size() != 0) begin
      report_mismatch($sformatf("%0d words never arrived", pending_words.size()));
    end
    if (mismatches == 0) begin
      $display("tb_mersenne_twister_generator_core: clean");
    end else begin
      $display("tb_mersenne_twister_generator_core: errors");
    end
    $finish;
  end

endmodule
